// File: design/lsfe_pkg.sv
// ---------------------------------------------------------------------------
// lsfe_pkg
// Shared types, opcodes and frame helpers for the lcd spi frame encoder.
// ---------------------------------------------------------------------------
package lsfe_pkg;

    // request opcodes as they arrive on the input tuser
    typedef enum logic [2:0] {
        OP_CMD = 3'd0,
        OP_DAT = 3'd1,
        OP_PIX = 3'd2,
        OP_WIN = 3'd3,
        OP_ROT = 3'd4
    } t_op;

    // job kinds carried through the queue
    typedef enum logic [2:0] {
        K_CMD,
        K_DAT,
        K_PIX,
        K_WIN,
        K_ROT
    } t_kind;

    // one classified request
    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
    } t_job;

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam int LSFE_QUEUE_DEPTH = 2;
    localparam int IDX_W            = 5;

    // lcd command codes
    localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;
    localparam logic [7:0] CMD_MADCTL    = 8'h36;

    // frame tags
    localparam logic [7:0] TAG_CMD_A = 8'h11;
    localparam logic [7:0] TAG_CMD_B = 8'h1B;
    localparam logic [7:0] TAG_DAT_A = 8'h15;
    localparam logic [7:0] TAG_DAT_B = 8'h1F;
    localparam logic [7:0] TAG_PIX_A = 8'h75;
    localparam logic [7:0] TAG_PIX_B = 8'h7F;

    // frame lengths
    localparam logic [1:0] LEN_SHORT = 2'd2;
    localparam logic [1:0] LEN_LONG  = 2'd3;

    // index of the final frame for each job kind
    localparam logic [IDX_W-1:0] LAST_BYTE_JOB = 5'd1;
    localparam logic [IDX_W-1:0] LAST_WIN_JOB  = 5'd21;
    localparam logic [IDX_W-1:0] LAST_ROT_JOB  = 5'd3;

    // rotation byte lookup
    function automatic logic [7:0] rot_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'b11101010;
            2'd1:    b = 8'b01001010;
            2'd2:    b = 8'h2A;
            default: b = 8'h8A;
        endcase
        return b;
    endfunction

    // one of the two 2-byte frames that carry a command or data byte
    function automatic logic [23:0] byte_frame(input logic [7:0] b,
                                               input logic       is_cmd,
                                               input logic       second);
        logic [7:0] tag;
        logic [7:0] low;
        if (is_cmd) begin
            tag = second ? TAG_CMD_B : TAG_CMD_A;
        end else begin
            tag = second ? TAG_DAT_B : TAG_DAT_A;
        end
        low = tag + {2'b00, b[0], 5'b00000};
        return {8'h00, 1'b0, b[7:1], low};
    endfunction

endpackage

// File: design/lsfe_front.sv
// ---------------------------------------------------------------------------
// lsfe_front
// Classifies requests into jobs and works out the window end coordinates.
// ---------------------------------------------------------------------------
module lsfe_front
    import lsfe_pkg::*;
(
    input  logic        i_valid,
    input  logic [2:0]  i_op,
    input  logic [79:0] i_data,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0] value;
    logic [15:0] win_x;
    logic [15:0] win_y;
    logic [15:0] win_w;
    logic [15:0] win_h;
    logic        known;

    assign value = i_data[15:0];
    assign win_x = i_data[31:16];
    assign win_y = i_data[47:32];
    assign win_w = i_data[63:48];
    assign win_h = i_data[79:64];

    // decode the opcode; unknown codes make no job
    always_comb begin
        known       = 1'b1;
        o_job.kind  = K_CMD;
        o_job.value = value;
        // window end coordinates wrap at 16 bits
        o_job.x_start = win_x;
        o_job.x_end   = win_x + win_w - 16'd1;
        o_job.y_start = win_y;
        o_job.y_end   = win_y + win_h - 16'd1;
        unique case (i_op)
            OP_CMD: begin
                o_job.kind  = K_CMD;
                o_job.value = {8'h00, value[7:0]};
            end
            OP_DAT: begin
                o_job.kind  = K_DAT;
                o_job.value = {8'h00, value[7:0]};
            end
            OP_PIX: begin
                o_job.kind = K_PIX;
            end
            OP_WIN: begin
                o_job.kind = K_WIN;
            end
            OP_ROT: begin
                o_job.kind  = K_ROT;
                o_job.value = {8'h00, rot_byte(value[1:0])};
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && known;

endmodule

// File: design/lsfe_queue.sv
// ---------------------------------------------------------------------------
// lsfe_queue
// Short job queue between the classifier and the frame sequencer.
// ---------------------------------------------------------------------------
module lsfe_queue
    import lsfe_pkg::*;
#(
    parameter int DEPTH = LSFE_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/lsfe_back.sv
// ---------------------------------------------------------------------------
// lsfe_back
// Steps through the frames of the head job into the output register, one
// per cycle while that register is empty or taken.
// ---------------------------------------------------------------------------
module lsfe_back
    import lsfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_bytes,
    output logic [1:0]  o_len,
    output logic        o_last
);

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_valid;
    logic [23:0]      r_bytes;
    logic [1:0]       r_len;
    logic             r_last;

    logic             load;
    logic [IDX_W-1:0] last_idx;
    logic [3:0]       byte_idx;
    logic [7:0]       cur_byte;
    logic             cur_cmd;
    logic [23:0]      frame;
    logic [1:0]       len;

    assign byte_idx = r_idx[IDX_W-1:1];

    // last frame index per job kind
    always_comb begin
        case (i_job.kind)
            K_WIN:   last_idx = LAST_WIN_JOB;
            K_ROT:   last_idx = LAST_ROT_JOB;
            default: last_idx = LAST_BYTE_JOB;
        endcase
    end

    // byte and command flag of each job; window and rotation jobs step through a byte sequence
    always_comb begin
        cur_byte = i_job.value[7:0];
        cur_cmd  = 1'b0;
        case (i_job.kind)
            K_CMD: begin
                cur_cmd = 1'b1;
            end
            K_WIN: begin
                unique case (byte_idx)
                    4'd0: begin
                        cur_byte = CMD_COL_ADDR;
                        cur_cmd  = 1'b1;
                    end
                    4'd1: cur_byte = i_job.x_start[15:8];
                    4'd2: cur_byte = i_job.x_start[7:0];
                    4'd3: cur_byte = i_job.x_end[15:8];
                    4'd4: cur_byte = i_job.x_end[7:0];
                    4'd5: begin
                        cur_byte = CMD_PAGE_ADDR;
                        cur_cmd  = 1'b1;
                    end
                    4'd6: cur_byte = i_job.y_start[15:8];
                    4'd7: cur_byte = i_job.y_start[7:0];
                    4'd8: cur_byte = i_job.y_end[15:8];
                    4'd9: cur_byte = i_job.y_end[7:0];
                    default: begin
                        cur_byte = CMD_MEM_WRITE;
                        cur_cmd  = 1'b1;
                    end
                endcase
            end
            K_ROT: begin
                if (byte_idx == 4'd0) begin
                    cur_byte = CMD_MADCTL;
                    cur_cmd  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // frame contents
    always_comb begin
        if (i_job.kind == K_PIX) begin
            frame = {i_job.value, r_idx[0] ? TAG_PIX_B : TAG_PIX_A};
            len   = LEN_LONG;
        end else begin
            frame = byte_frame(cur_byte, cur_cmd, r_idx[0]);
            len   = LEN_SHORT;
        end
    end

    // output register refills when empty or taken
    assign load  = i_job_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_idx == last_idx);

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = o_pop ? '0 : r_idx + 1'b1;
        end
    end

    // frame counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= frame;
            r_len   <= len;
            r_last  <= o_pop;
        end
    end

    assign o_valid = r_valid;
    assign o_bytes = r_bytes;
    assign o_len   = r_len;
    assign o_last  = r_last;

endmodule

// File: design/lcd_spi_frame_encoder.sv
// ---------------------------------------------------------------------------
// lcd_spi_frame_encoder
// Turns display requests into the chip-select framed spi transfers of the
// lcd, with the final frame of each request marked.
// ---------------------------------------------------------------------------
//
// channel | dir | handshake                | payload
// --------+-----+--------------------------+-------------------------------
// request | in  | i_s_tvalid / o_s_tready  | i_s_tdata, i_s_tuser (op)
// frame   | out | o_m_tvalid / i_m_tready  | o_m_tdata, o_m_tlast
//
// one frame leaves per cycle while the output is not stalled; a request
// has as many frames as its kind: 2 for byte and pixel requests, 4 for
// rotation, 22 for window. the frame sequencer sets the frame rate; the
// job queue takes requests until full while it runs, and the classifier
// drops unknown opcodes at once. reset clears the queue and the sequencer;
// a stalled output holds its frame while the queue keeps filling.
module lcd_spi_frame_encoder
    import lsfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = LSFE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // value[15:0], win_x[31:16], win_y[47:32], win_w[63:48], win_h[79:64]
    input  logic [79:0] i_s_tdata,
    // op[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // frame_bytes[23:0], frame_len[25:24], zero[31:26]
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast
);

    logic        in_xact;
    logic        push;
    t_job        front_job;
    t_job        head_job;
    t_qstat      qstat;
    logic        pop;
    logic [23:0] frame_bytes;
    logic [1:0]  frame_len;

    assign o_s_tready = !qstat.full;
    assign in_xact    = i_s_tvalid && o_s_tready;

    // request classifier
    lsfe_front u_front (
        .i_valid (in_xact),
        .i_op    (i_s_tuser),
        .i_data  (i_s_tdata),
        .o_push  (push),
        .o_job   (front_job)
    );

    // job queue
    lsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    // frame sequencer
    lsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!qstat.empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_bytes     (frame_bytes),
        .o_len       (frame_len),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {6'b000000, frame_len, frame_bytes};

    // short frames keep the top byte clear, long frames only come from pixels
    a_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (frame_len == LEN_SHORT && frame_bytes[23:16] == 8'h00) ||
                       (frame_len == LEN_LONG &&
                        (frame_bytes[7:0] == TAG_PIX_A || frame_bytes[7:0] == TAG_PIX_B)))
        else $error("malformed frame");

    // an unknown opcode never adds a queue entry
    a_drop_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && !push) |=> !($past(qstat.empty) && !qstat.empty && !$past(pop)))
        else $error("unknown request queued");

    // a job leaves the queue only on a frame marked last
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_m_tvalid && o_m_tlast))
        else $error("job retired without last frame");

endmodule
